// ===== rtl/sorted_insert_priority_queue_assert.svh =====
// assertion macros for the priority queue top level
`ifndef SORTED_INSERT_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_INSERT_PRIORITY_QUEUE_ASSERT_SVH

// property checked at every rising clock edge outside reset
`define SPIQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition in one cycle implies a consequence in the next
`define SPIQ_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== rtl/spiq_pkg.sv =====
// shared types and constants of the sorted-insert priority queue
`timescale 1ns / 1ps
`default_nettype none

package spiq_pkg;

  localparam int CapacityDef = 16;
  localparam int PrioW       = 8;
  localparam int CharW       = 8;
  localparam int StatusW     = 2;
  localparam int CountOutW   = 5;

  localparam logic [StatusW-1:0] StOk    = 2'd0;
  localparam logic [StatusW-1:0] StFull  = 2'd1;
  localparam logic [StatusW-1:0] StEmpty = 2'd2;

  localparam logic OpEnq = 1'b0;
  localparam logic OpDeq = 1'b1;

  typedef struct packed {
    logic [PrioW-1:0] prio;
    logic [CharW-1:0] chr;
  } entry_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic shift_in;   // insert the new entry, cells above the slot move back
    logic shift_out;  // head leaves, every cell takes its right neighbour
  } ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/spiq_cell.sv =====
// one storage cell of the shift-register priority queue
`timescale 1ns / 1ps
`default_nettype none

module spiq_cell (
  input  wire                     clk_i,
  input  wire spiq_pkg::ctrl_t    ctrl_i,
  input  wire spiq_pkg::entry_t   new_entry_i,
  input  wire                     occupied_i,
  input  wire                     left_stay_i,
  input  wire spiq_pkg::entry_t   left_entry_i,
  input  wire spiq_pkg::entry_t   right_entry_i,
  output spiq_pkg::entry_t        entry_o,
  output logic                    stay_o
);
  import spiq_pkg::*;

  entry_t entry_q, entry_d;

  // held entry is not later than the new one, so it keeps its place
  assign stay_o  = occupied_i && (entry_q.prio <= new_entry_i.prio);
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.shift_in) begin
      if (stay_o) begin
        entry_d = entry_q;
      end else if (left_stay_i) begin
        entry_d = new_entry_i;
      end else begin
        entry_d = left_entry_i;
      end
    end else if (ctrl_i.shift_out) begin
      entry_d = right_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

`default_nettype wire

// ===== rtl/sorted_insert_priority_queue.sv =====
// top level of the sorted-insert priority queue built as a chain of cells
//
//  channel  dir  tdata (low bit up)                        tuser
//  s_axis   in   entry_prio[7:0] entry_char[15:8]          op[0]
//  m_axis   out  out_prio[7:0] out_char[15:8] count[20:16] status[1:0]
//                is_empty[21] is_full[22] zero[23]
//
//  one request per cycle unless stalled; its result is in the output register on the next
//  the whole chain of cells updates in that one cycle: each cell compares its own
//  priority with the new one and picks keep, new, left or right neighbour
//  while a result waits unaccepted, s_axis_tready stays low unless it leaves this cycle
//  reset clears the fill count and the output valid; cell contents need no clearing
`timescale 1ns / 1ps
`default_nettype none

module sorted_insert_priority_queue #(
  parameter int CAPACITY = spiq_pkg::CapacityDef
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [15:0] s_axis_tdata,   // entry_prio, entry_char
  input  wire  [0:0]  s_axis_tuser,   // op
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [23:0] m_axis_tdata,   // out_prio, out_char, count, is_empty, is_full, pad
  output logic [1:0]  m_axis_tuser    // status
);
  import spiq_pkg::*;

  localparam int CntW = $clog2(CAPACITY + 1);

  // fill count: cells below it hold valid entries in sorted order
  logic [CntW-1:0] count_q, count_d;

  logic   accept;
  logic   op;
  entry_t new_entry;
  ctrl_t  ctrl;
  logic   is_full_now;
  logic   is_empty_now;

  entry_t cell_entry [CAPACITY];
  logic   cell_stay  [CAPACITY];

  // result register
  logic               res_valid_q;
  logic [StatusW-1:0] res_status_q, res_status_d;
  entry_t             res_entry_q, res_entry_d;
  logic [CntW-1:0]    res_count_q;

  assign s_axis_tready  = !res_valid_q || m_axis_tready;
  assign accept         = s_axis_tvalid && s_axis_tready;
  assign op             = s_axis_tuser[0];
  assign new_entry.prio = s_axis_tdata[PrioW-1:0];
  assign new_entry.chr  = s_axis_tdata[PrioW+CharW-1:PrioW];

  assign is_full_now  = (count_q == CntW'(CAPACITY));
  assign is_empty_now = (count_q == '0);

  // rejected requests leave the chain untouched
  assign ctrl.shift_in  = accept && (op == OpEnq) && !is_full_now;
  assign ctrl.shift_out = accept && (op == OpDeq) && !is_empty_now;

  // the chain: cell 0 is the head
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic   occupied;
    logic   left_stay;
    entry_t left_entry;
    entry_t right_entry;

    assign occupied = (CntW'(i) < count_q);

    if (i == 0) begin : g_head
      assign left_stay  = 1'b1;
      assign left_entry = new_entry;
    end else begin : g_body
      assign left_stay  = cell_stay[i-1];
      assign left_entry = cell_entry[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_entry = '0;
    end else begin : g_inner
      assign right_entry = cell_entry[i+1];
    end

    spiq_cell u_cell (
      .clk_i         (clk_i),
      .ctrl_i        (ctrl),
      .new_entry_i   (new_entry),
      .occupied_i    (occupied),
      .left_stay_i   (left_stay),
      .left_entry_i  (left_entry),
      .right_entry_i (right_entry),
      .entry_o       (cell_entry[i]),
      .stay_o        (cell_stay[i])
    );
  end

  // count and result of the request taken this cycle
  always_comb begin
    count_d      = count_q;
    res_status_d = StOk;
    res_entry_d  = '0;
    if (op == OpEnq) begin
      if (is_full_now) begin
        res_status_d = StFull;
      end else begin
        count_d = count_q + CntW'(1);
      end
    end else begin
      if (is_empty_now) begin
        res_status_d = StEmpty;
      end else begin
        count_d     = count_q - CntW'(1);
        res_entry_d = cell_entry[0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        res_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_status_q <= res_status_d;
      res_entry_q  <= res_entry_d;
      res_count_q  <= count_d;
    end
  end

  assign m_axis_tvalid = res_valid_q;
  assign m_axis_tuser  = res_status_q;
  assign m_axis_tdata  = {1'b0,
                          (res_count_q == CntW'(CAPACITY)),
                          (res_count_q == '0),
                          CountOutW'(res_count_q),
                          res_entry_q.chr,
                          res_entry_q.prio};

  `include "sorted_insert_priority_queue_assert.svh"

  `SPIQ_ASSERT(a_count_bound, count_q <= CntW'(CAPACITY), "fill count above capacity")
  `SPIQ_ASSERT(a_head_sorted, (count_q >= CntW'(2)) |-> (cell_entry[0].prio <= cell_entry[1].prio), "head out of order")
  `SPIQ_ASSERT_NEXT(a_deq_count, ctrl.shift_out, count_q == $past(count_q) - CntW'(1), "dequeue did not drop count")
  `SPIQ_ASSERT_NEXT(a_deq_head, ctrl.shift_out, res_entry_q.prio == $past(cell_entry[0].prio), "dequeued entry is not the head")
  `SPIQ_ASSERT_NEXT(a_full_reject, accept && (op == OpEnq) && is_full_now, $stable(count_q) && (res_status_q == StFull), "full enqueue not rejected")

endmodule

`default_nettype wire

// ===== dv/sorted_insert_priority_queue_test.sv =====
// self-checking stream testbench for the sorted-insert priority queue
`timescale 1ns / 1ps

module sorted_insert_priority_queue_test;
  import spiq_pkg::*;

  localparam int QDepth     = CapacityDef;
  localparam int StallLimit = 4000;
  localparam int TailCycles = 10;

  typedef struct {
    logic             op;
    logic [PrioW-1:0] prio;
    logic [CharW-1:0] chr;
    bit               drain_first;  // hold off until every reply is back
  } request_t;

  typedef struct packed {
    logic [StatusW-1:0]   status;
    logic [PrioW-1:0]     prio;
    logic [CharW-1:0]     chr;
    logic [CountOutW-1:0] count;
    logic                 is_empty;
    logic                 is_full;
  } reply_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;   // entry_prio, entry_char
  logic [0:0]  s_axis_tuser = '0;   // op
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;        // out_prio, out_char, count, is_empty, is_full, pad
  logic [1:0]  m_axis_tuser;        // status

  sorted_insert_priority_queue dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  // shadow copy of the queue contents
  entry_t   held [QDepth+1];
  int       held_count = 0;

  request_t request_backlog[$];
  reply_t   predicted_replies[$];
  bit       in_flight = 1'b0;
  int       requests_total = 0;
  int       requests_taken = 0;
  int       replies_seen = 0;
  int       error_count = 0;
  int       stall_cycles = 0;

  function automatic reply_t apply_queue_op(request_t rq);
    reply_t r;
    int     slot;
    int     i;
    r = '0;
    r.status = StOk;
    if (rq.op == OpEnq) begin
      if (held_count >= QDepth) begin
        r.status = StFull;
      end else begin
        // slot goes after every entry of lower or equal priority
        slot = 0;
        while (slot < held_count && held[slot].prio <= rq.prio) slot++;
        for (i = held_count; i > slot; i--) held[i] = held[i-1];
        held[slot].prio = rq.prio;
        held[slot].chr  = rq.chr;
        held_count++;
      end
    end else begin
      if (held_count == 0) begin
        r.status = StEmpty;
      end else begin
        r.prio = held[0].prio;
        r.chr  = held[0].chr;
        for (i = 1; i < held_count; i++) held[i-1] = held[i];
        held_count--;
      end
    end
    r.count    = held_count[CountOutW-1:0];
    r.is_empty = (held_count == 0);
    r.is_full  = (held_count >= QDepth);
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("reply %0d: %s got %0d expected %0d", replies_seen, what, got, want);
    error_count++;
  endtask

  // idle percentages move through three phases of the run
  function automatic int sender_idle_pct();
    int phase;
    phase = (requests_taken * 3) / (requests_total + 1);
    return (phase == 0) ? 11 : (phase == 1) ? 63 : 0;
  endfunction

  function automatic int receiver_idle_pct();
    int phase;
    phase = (requests_taken * 3) / (requests_total + 1);
    return (phase == 0) ? 63 : (phase == 1) ? 11 : 0;
  endfunction

  // request driver, changes inputs on the falling edge
  always @(negedge clk_i) begin
    if (rst_ni) begin
      m_axis_tready <= ($urandom_range(99) >= receiver_idle_pct());
      if (!in_flight) begin
        if (request_backlog.size() == 0 ||
            (request_backlog[0].drain_first && predicted_replies.size() != 0) ||
            $urandom_range(99) < sender_idle_pct()) begin
          s_axis_tvalid <= 1'b0;
        end else begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {request_backlog[0].chr, request_backlog[0].prio};
          s_axis_tuser  <= request_backlog[0].op;
          in_flight = 1'b1;
        end
      end
    end
  end

  // monitor and checker, samples on the rising edge
  always @(posedge clk_i) begin
    reply_t want;
    if (rst_ni) begin
      stall_cycles++;
      if (m_axis_tvalid && m_axis_tready) begin
        stall_cycles = 0;
        if (predicted_replies.size() == 0) begin
          report_mismatch("unexpected reply, status", m_axis_tuser, 0);
        end else begin
          want = predicted_replies.pop_front();
          if (m_axis_tuser !== want.status)
            report_mismatch("status", m_axis_tuser, want.status);
          if (m_axis_tdata[7:0] !== want.prio)
            report_mismatch("out_prio", m_axis_tdata[7:0], want.prio);
          if (m_axis_tdata[15:8] !== want.chr)
            report_mismatch("out_char", m_axis_tdata[15:8], want.chr);
          if (m_axis_tdata[20:16] !== want.count)
            report_mismatch("count", m_axis_tdata[20:16], want.count);
          if (m_axis_tdata[21] !== want.is_empty)
            report_mismatch("is_empty", m_axis_tdata[21], want.is_empty);
          if (m_axis_tdata[22] !== want.is_full)
            report_mismatch("is_full", m_axis_tdata[22], want.is_full);
        end
        replies_seen++;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        stall_cycles = 0;
        predicted_replies.push_back(apply_queue_op(request_backlog.pop_front()));
        requests_taken++;
        in_flight = 1'b0;
      end
    end
  end

  function automatic logic [PrioW-1:0] pick_prio();
    case ($urandom_range(2))
      0:       return PrioW'($urandom_range(7));    // many ties
      1:       return $urandom_range(1) ? 8'hff : 8'h00;
      default: return PrioW'($urandom_range(255));
    endcase
  endfunction

  task automatic add_request(logic op, logic [PrioW-1:0] prio, logic [CharW-1:0] chr,
                             bit drain_first);
    request_t rq;
    rq.op          = op;
    rq.prio        = prio;
    rq.chr         = chr;
    rq.drain_first = drain_first;
    request_backlog.push_back(rq);
    requests_total++;
  endtask

  initial begin
    int burst;
    int burst_len;
    int enq_pct;
    int n;
    int i;

    // directed: empty dequeue with junk payload, extremes, ties, fill to full
    add_request(OpDeq, 8'hff, 8'hff, 1'b0);
    add_request(OpEnq, 8'hff, 8'h00, 1'b0);
    add_request(OpEnq, 8'h00, 8'hff, 1'b0);
    add_request(OpEnq, 8'h80, 8'haa, 1'b0);
    add_request(OpEnq, 8'h80, 8'h55, 1'b0);
    add_request(OpDeq, 8'h00, 8'h00, 1'b0);
    for (i = 0; i < QDepth - 3; i++)
      add_request(OpEnq, 8'((i * 37) % 9 + 8'h7c), 8'(~i), 1'b0);
    add_request(OpEnq, 8'h01, 8'h01, 1'b0);   // queue full, rejected
    add_request(OpDeq, 8'h00, 8'h00, 1'b1);

    // random bursts with a bias that swings the queue between empty and full
    n = 0;
    burst = 0;
    while (n < 850) begin
      burst_len = $urandom_range(40, 10);
      case ($urandom_range(2))
        0:       enq_pct = 80;
        1:       enq_pct = 50;
        default: enq_pct = 20;
      endcase
      for (i = 0; i < burst_len; i++) begin
        add_request(($urandom_range(99) < enq_pct) ? OpEnq : OpDeq, pick_prio(),
                    8'($urandom_range(255)), (i == 0) && (burst % 7 == 3));
        n++;
      end
      burst++;
    end

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while ((request_backlog.size() != 0 || predicted_replies.size() != 0) &&
           stall_cycles < StallLimit)
      @(posedge clk_i);

    if (stall_cycles >= StallLimit) begin
      $display("Testbench completed WITH ERRORS");
    end else begin
      repeat (TailCycles) @(posedge clk_i);
      if (error_count == 0) begin
        $display("Testbench completed without errors");
      end else begin
        $display("Testbench completed WITH ERRORS");
      end
    end
    $finish;
  end

endmodule
